>>> rtl/teq_pkg.sv
`timescale 1ns / 1ps

package teq_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;

	localparam int TIME_W     = 32;
	localparam int PIN_W      = 8;
	localparam int TAG_W      = 8;
	localparam int SECS_W     = 23;
	localparam int OP_W       = 3;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 48;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_ABS   = 3'd1;
	localparam logic [OP_W-1:0] OP_ADD_DELAY = 3'd2;
	localparam logic [OP_W-1:0] OP_QUERY     = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

	// ms to s: q = (a * floor(2^41 / 1000)) >> 41, low by at most one
	localparam int               MS_PER_SEC  = 1000;
	localparam logic [TIME_W-1:0] RECIP_1000 = 32'h83126E97;
	localparam int               RECIP_SHIFT = 41;

	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [PIN_W-1:0]  pin;
		logic              level;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef struct packed {
		logic load;
		logic due_ld;
		logic drop;
		logic cmp;
		logic ins;
		logic fire;
		logic clear;
		logic qflag;
		logic qstep;
		logic qhit;
		logic diff;
		logic absv;
		logic mul;
		logic rem;
		logic fix;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            empty;
		logic            tick_ok;
		logic            qmatch;
		logic            idx_zero;
	} status_t;

endpackage

>>> rtl/teq_ctrl.sv
`timescale 1ns / 1ps

module teq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  teq_pkg::status_t st,
	output teq_pkg::cmd_t    cmd
);
	import teq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_DROP, ST_CMP, ST_INS, ST_TICK, ST_QFLAG, ST_QWALK,
		ST_DIFF, ST_ABS, ST_MUL, ST_REM, ST_FIX, ST_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (st.op)
					OP_TICK: state_d = ST_TICK;
					OP_ADD_ABS, OP_ADD_DELAY: begin
						cmd.due_ld = 1'b1;
						state_d    = st.full ? ST_DROP : ST_CMP;
					end
					OP_QUERY: state_d = st.empty ? ST_FINISH : ST_QFLAG;
					OP_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = ST_FINISH;
					end
					default: state_d = ST_FINISH;
				endcase
			end
			ST_DROP: begin
				cmd.drop = 1'b1;
				state_d  = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_INS;
			end
			ST_INS: begin
				cmd.ins = 1'b1;
				state_d = ST_FINISH;
			end
			ST_TICK: begin
				cmd.fire = st.tick_ok;
				state_d  = ST_FINISH;
			end
			ST_QFLAG: begin
				cmd.qflag = 1'b1;
				state_d   = ST_QWALK;
			end
			ST_QWALK: begin
				if (st.qmatch) begin
					cmd.qhit = 1'b1;
					state_d  = ST_DIFF;
				end else if (st.idx_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.qstep = 1'b1;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_ABS;
			end
			ST_ABS: begin
				cmd.absv = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_REM;
			end
			ST_REM: begin
				cmd.rem = 1'b1;
				state_d = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/teq_dp.sv
`timescale 1ns / 1ps

module teq_dp #(
	parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  teq_pkg::cmd_t                    cmd,
	output teq_pkg::status_t                 st,
	input  logic [teq_pkg::IN_DATA_W-1:0]    in_data,
	input  logic [teq_pkg::OP_W-1:0]         in_user,
	output logic [teq_pkg::OUT_DATA_W-1:0]   out_data
);
	import teq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// latched input word
	logic [OP_W-1:0]   op_q;
	logic [TIME_W-1:0] now_q, etime_q, due_q;
	logic [PIN_W-1:0]  pin_q;
	logic              level_q;
	logic [TAG_W-1:0]  tag_q;

	// sorted pool, earliest in cell 0
	entry_t                 ent_q [QUEUE_DEPTH];
	logic [CW-1:0]          count_q;
	logic [QUEUE_DEPTH-1:0] gt_q;
	logic [QUEUE_DEPTH-1:0] match_q;
	logic [IW-1:0]          idx_q;

	// seconds conversion
	logic [TIME_W-1:0]   sel_q, diff_q, abs_q;
	logic                neg_q;
	logic [2*TIME_W-1:0] prod_q;
	logic [SECS_W-1:0]   qe_q, q_fix;
	logic [10:0]         rem_q;

	// result fields
	logic                     fired_q, flevel_q, found_q, displaced_q;
	logic [PIN_W-1:0]         fpin_q;
	logic [TAG_W-1:0]         ftag_q;
	logic signed [SECS_W-1:0] secs_q;

	entry_t new_ent;

	assign new_ent = '{due: due_q, pin: pin_q, level: level_q, tag: tag_q};
	assign q_fix   = (rem_q >= 11'(MS_PER_SEC)) ? qe_q + SECS_W'(1) : qe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (cmd.clear)
				count_q <= '0;
			else if (cmd.drop || cmd.fire)
				count_q <= count_q - CW'(1);
			else if (cmd.ins)
				count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= in_user;
			now_q       <= in_data[31:0];
			etime_q     <= in_data[63:32];
			pin_q       <= in_data[71:64];
			level_q     <= in_data[72];
			tag_q       <= in_data[80:73];
			fired_q     <= 1'b0;
			fpin_q      <= '0;
			flevel_q    <= 1'b0;
			ftag_q      <= '0;
			found_q     <= 1'b0;
			secs_q      <= '0;
			displaced_q <= 1'b0;
		end

		if (cmd.due_ld)
			due_q <= (op_q == OP_ADD_DELAY) ? now_q + etime_q : etime_q;

		if (cmd.drop)
			displaced_q <= 1'b1;

		if (cmd.fire) begin
			fired_q  <= 1'b1;
			fpin_q   <= ent_q[0].pin;
			flevel_q <= ent_q[0].level;
			ftag_q   <= ent_q[0].tag;
		end

		// shift out the head cell
		if (cmd.drop || cmd.fire) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++)
				ent_q[i] <= ent_q[i + 1];
		end

		// cells past the count or later than the new due time move up
		if (cmd.cmp) begin
			for (int i = 0; i < QUEUE_DEPTH; i++)
				gt_q[i] <= (CW'(i) >= count_q) || (due_q < ent_q[i].due);
		end

		if (cmd.ins) begin
			if (gt_q[0])
				ent_q[0] <= new_ent;
			for (int i = 1; i < QUEUE_DEPTH; i++) begin
				if (gt_q[i - 1])
					ent_q[i] <= ent_q[i - 1];
				else if (gt_q[i])
					ent_q[i] <= new_ent;
			end
		end

		// query walks back from the latest entry
		if (cmd.qflag) begin
			for (int i = 0; i < QUEUE_DEPTH; i++)
				match_q[i] <= (CW'(i) < count_q) && (ent_q[i].tag == tag_q);
			idx_q <= IW'(count_q - CW'(1));
		end
		if (cmd.qstep)
			idx_q <= idx_q - IW'(1);
		if (cmd.qhit)
			sel_q <= ent_q[idx_q].due;

		if (cmd.diff)
			diff_q <= sel_q - now_q;
		if (cmd.absv) begin
			neg_q <= diff_q[TIME_W-1];
			abs_q <= diff_q[TIME_W-1] ? ~diff_q + TIME_W'(1) : diff_q;
		end
		if (cmd.mul)
			prod_q <= (2*TIME_W)'(abs_q) * (2*TIME_W)'(RECIP_1000);
		if (cmd.rem) begin
			qe_q  <= prod_q[2*TIME_W-1:RECIP_SHIFT];
			rem_q <= 11'(abs_q - TIME_W'(prod_q[2*TIME_W-1:RECIP_SHIFT])
				* TIME_W'(MS_PER_SEC));
		end
		if (cmd.fix) begin
			found_q <= 1'b1;
			secs_q  <= neg_q ? signed'(~q_fix + SECS_W'(1)) : signed'(q_fix);
		end

		if (cmd.out_ld)
			out_data <= {5'b0, displaced_q, secs_q, found_q, ftag_q, flevel_q, fpin_q,
				fired_q};
	end

	always_comb begin
		st          = '0;
		st.op       = op_q;
		st.full     = (count_q >= CW'(QUEUE_DEPTH));
		st.empty    = (count_q == '0);
		st.tick_ok  = (count_q != '0) && (now_q > ent_q[0].due);
		st.qmatch   = match_q[idx_q];
		st.idx_zero = (idx_q == '0);
	end

endmodule

>>> rtl/timed_event_queue_core.sv
`timescale 1ns / 1ps

// channel  | dir | handshake         | payload
// ---------+-----+-------------------+----------------------------------------
// s        | in  | s_tvalid/s_tready | tuser operation, tdata event word
// m        | out | m_tvalid/m_tready | tdata result word, one per input word
//
// add: decode, then drop the head when the pool is full, compare and shift into place
// tick fires the head if due; query walks up to QUEUE_DEPTH entries back, converts on a hit
// the query walk over the pool and the ms to s conversion set the longest path
// reset empties the pool at once; entries are only read below the count
// a new word is taken while the previous result still waits on m
// a finished result holds the sequencer until m has taken the word before it

module timed_event_queue_core #(
	parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// now_ms[31:0], event_time[63:32], pin_number[71:64], pin_level[72],
	// tag[80:73], zero pad
	input  logic [teq_pkg::IN_DATA_W-1:0]     s_tdata,
	// operation[2:0]
	input  logic [teq_pkg::OP_W-1:0]          s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// fired[0], fired_pin[8:1], fired_level[9], fired_tag[17:10], found[18],
	// seconds_left[41:19] (signed), displaced[42], zero pad
	output logic [teq_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import teq_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencer: one word at a time
	teq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.st        (st),
		.cmd       (cmd)
	);

	// sorted pool, query walk and seconds conversion
	teq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.in_data  (s_tdata),
		.in_user  (s_tuser),
		.out_data (m_tdata)
	);

`ifndef SYNTHESIS
	// a word in flight blocks the next one
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word taken while one is in flight");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!m_tvalid || m_tready))
		else $error("result register loaded over an untaken word");

	// insertion only into a pool with room
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> !st.full)
		else $error("insert into a full pool");

	// firing only from a non-empty pool
	a_fire_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire |-> !st.empty)
		else $error("tick fired from an empty pool");
`endif

endmodule

>>> tb/sv/timed_event_queue_core_tb.sv
`timescale 1ns / 1ps

module timed_event_queue_core_tb;
	import teq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;

	// one result word, split into its fields
	typedef struct packed {
		logic                     fired;
		logic [PIN_W-1:0]         fired_pin;
		logic                     fired_level;
		logic [TAG_W-1:0]         fired_tag;
		logic                     found;
		logic signed [SECS_W-1:0] secs_left;
		logic                     displaced;
	} outcome_t;

	// shadow of the event pool, kept sorted by due time like the block
	class event_queue_scoreboard;
		logic [TIME_W-1:0] due_ms[DEPTH];
		logic [PIN_W-1:0]  pin_of[DEPTH];
		logic              level_of[DEPTH];
		logic [TAG_W-1:0]  tag_of[DEPTH];
		int unsigned       held;
		outcome_t          expected_outcomes[$];
		int                mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		function void drop_head();
			for (int i = 0; i + 1 < held; i++) begin
				due_ms[i] = due_ms[i+1];
				pin_of[i] = pin_of[i+1];
				level_of[i] = level_of[i+1];
				tag_of[i] = tag_of[i+1];
			end
			if (held > 0)
				held--;
		endfunction

		function logic insert_entry(logic [TIME_W-1:0] due, logic [PIN_W-1:0] pin,
				logic lvl, logic [TAG_W-1:0] tag);
			logic dropped;
			int unsigned pos;
			dropped = 1'b0;
			pos = 0;
			if (held >= DEPTH) begin
				drop_head();
				dropped = 1'b1;
			end
			// equal due times go behind the ones already queued
			while (pos < held && !(due < due_ms[pos]))
				pos++;
			for (int i = held; i > pos; i--) begin
				due_ms[i] = due_ms[i-1];
				pin_of[i] = pin_of[i-1];
				level_of[i] = level_of[i-1];
				tag_of[i] = tag_of[i-1];
			end
			due_ms[pos] = due;
			pin_of[pos] = pin;
			level_of[pos] = lvl;
			tag_of[pos] = tag;
			held++;
			return dropped;
		endfunction

		function void note_word(logic [OP_W-1:0] op, logic [TIME_W-1:0] now,
				logic [TIME_W-1:0] etime, logic [PIN_W-1:0] pin, logic lvl,
				logic [TAG_W-1:0] tag);
			outcome_t o;
			logic [TIME_W-1:0] diff;
			int secs;
			logic hit;
			o = '0;
			hit = 1'b0;
			case (op)
				OP_TICK: begin
					if (held > 0 && now > due_ms[0]) begin
						o.fired = 1'b1;
						o.fired_pin = pin_of[0];
						o.fired_level = level_of[0];
						o.fired_tag = tag_of[0];
						drop_head();
					end
				end
				OP_ADD_ABS: o.displaced = insert_entry(etime, pin, lvl, tag);
				OP_ADD_DELAY: o.displaced = insert_entry(now + etime, pin, lvl, tag);
				OP_QUERY: begin
					// latest matching entry wins
					for (int i = int'(held) - 1; i >= 0; i--) begin
						if (!hit && tag_of[i] == tag) begin
							hit = 1'b1;
							diff = due_ms[i] - now;
							secs = $signed(diff) / MS_PER_SEC;
							o.found = 1'b1;
							o.secs_left = secs[SECS_W-1:0];
						end
					end
				end
				OP_CLEAR: held = 0;
				default: ;
			endcase
			expected_outcomes = {expected_outcomes, o};
		endfunction

		function void check_word(logic [OUT_DATA_W-1:0] w);
			outcome_t got;
			outcome_t want;
			got.fired = w[0];
			got.fired_pin = w[8:1];
			got.fired_level = w[9];
			got.fired_tag = w[17:10];
			got.found = w[18];
			got.secs_left = w[41:19];
			got.displaced = w[42];
			if (expected_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", w);
				return;
			end
			want = expected_outcomes.pop_front();
			if (got.fired !== want.fired || got.fired_pin !== want.fired_pin ||
					got.fired_level !== want.fired_level ||
					got.fired_tag !== want.fired_tag || got.found !== want.found ||
					got.secs_left !== want.secs_left ||
					got.displaced !== want.displaced) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected fired %b pin %0d level %b tag %0d ",
						"found %b secs %0d displaced %b, got fired %b pin %0d ",
						"level %b tag %0d found %b secs %0d displaced %b"},
						want.fired, want.fired_pin, want.fired_level, want.fired_tag,
						want.found, want.secs_left, want.displaced,
						got.fired, got.fired_pin, got.fired_level, got.fired_tag,
						got.found, got.secs_left, got.displaced);
			end
		endfunction

		function int outstanding();
			return expected_outcomes.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	event_queue_scoreboard sb = new();

	int src_idle_pct;
	int snk_idle_pct;
	int hold_asks;

	timed_event_queue_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// offer one word, idling beforehand at the current sender rate
	task automatic offer(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] etime, input logic [PIN_W-1:0] pin,
			input logic lvl, input logic [TAG_W-1:0] tag);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, tag, lvl, pin, etime, now};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_word(op, now, etime, pin, lvl, tag);
	endtask

	// receiver: checks results, stalls at random, and holds off on request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready)
				sb.check_word(m_tdata);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// stimulus
	initial begin
		logic [OP_W-1:0]   op;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] etime;
		logic [PIN_W-1:0]  pin;
		logic              lvl;
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] clock_ms;
		int                counted;
		int                pick;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_TICK;
		hold_asks <= 0;
		src_idle_pct = 8;
		snk_idle_pct = 56;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		offer(OP_TICK, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0);            // empty pool
		offer(OP_QUERY, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0);
		offer(OP_ADD_ABS, 32'd0, 32'd1000, 8'hFF, 1'b1, 8'hFF);
		offer(OP_ADD_DELAY, 32'hFFFF_FF00, 32'h200, 8'd0, 1'b0, 8'd0); // due wraps
		offer(OP_TICK, 32'h100, 32'd0, 8'd0, 1'b0, 8'd0);          // equal, no fire
		offer(OP_TICK, 32'h101, 32'd0, 8'd0, 1'b0, 8'd0);
		offer(OP_QUERY, 32'd0, 32'd0, 8'd0, 1'b0, 8'hFF);
		offer(OP_QUERY, 32'h8000_03E8, 32'd0, 8'd0, 1'b0, 8'hFF);   // most negative
		offer(OP_QUERY, 32'd3, 32'd0, 8'd0, 1'b0, 8'h42);           // absent tag
		offer(OP_ADD_ABS, 32'd0, 32'hFFFF_FFFF, 8'd4, 1'b0, 8'd5);
		offer(OP_ADD_ABS, 32'd0, 32'd0, 8'd5, 1'b1, 8'd5);
		offer(OP_ADD_ABS, 32'd0, 32'd1000, 8'd1, 1'b0, 8'd7);       // equal due times
		offer(OP_ADD_ABS, 32'd0, 32'd1000, 8'd2, 1'b1, 8'd7);
		offer(OP_QUERY, 32'd0, 32'd0, 8'd0, 1'b0, 8'd5);            // just under zero
		offer(OP_QUERY, 32'd5, 32'd0, 8'd0, 1'b0, 8'd0);            // untagged, gone
		offer(OP_ADD_DELAY, 32'd10, 32'd990, 8'd3, 1'b1, 8'd3);
		offer(OP_ADD_ABS, 32'd0, 32'd500, 8'd6, 1'b0, 8'd1);
		offer(OP_ADD_ABS, 32'd0, 32'd2000, 8'd8, 1'b1, 8'd2);       // pool now full
		offer(OP_ADD_ABS, 32'd0, 32'd1000, 8'd9, 1'b0, 8'd9);       // drops earliest
		offer(OP_ADD_DELAY, 32'hFFFF_FFFF, 32'd1, 8'd10, 1'b1, 8'd0);
		offer(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 8'hFF);
		offer(3'd6, 32'd1, 32'd2, 8'd3, 1'b0, 8'd4);
		offer(3'd7, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'hAA, 1'b1, 8'h55);
		repeat (3) offer(OP_TICK, 32'd1001, 32'd0, 8'd0, 1'b0, 8'd0);
		offer(OP_CLEAR, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0);
		offer(OP_TICK, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b0, 8'd0);
		offer(OP_QUERY, 32'd0, 32'd0, 8'd0, 1'b0, 8'd7);

		// random part: mostly a running clock with events due close to it
		clock_ms = $urandom;
		counted = 0;
		while (counted < 650) begin
			if (counted == 220) begin
				src_idle_pct = 56;
				snk_idle_pct = 8;
			end else if (counted == 440) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
				// long receiver stall while words keep coming
				hold_asks <= hold_asks + 1;
			end
			pick = $urandom_range(99);
			pin = 8'($urandom_range(255));
			lvl = 1'($urandom_range(1));
			tag = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
			etime = 32'($urandom_range(2000));
			if (pick < 30) begin
				op = OP_TICK;
				clock_ms = clock_ms + 32'($urandom_range(300));
			end else if (pick < 50) begin
				op = OP_ADD_ABS;
				etime = clock_ms + etime;
			end else if (pick < 65) begin
				op = OP_ADD_DELAY;
			end else if (pick < 80) begin
				op = OP_QUERY;
			end else if (pick < 83) begin
				op = OP_CLEAR;
			end else if (pick < 87) begin
				op = OP_W'($urandom_range(7, 5));
				etime = $urandom;
			end else begin
				// noise over the whole field ranges
				op = OP_W'($urandom_range(4));
				etime = $urandom;
				tag = 8'($urandom_range(255));
				if ($urandom_range(3) == 0)
					clock_ms = $urandom;
			end
			now = (pick >= 87 && $urandom_range(1) == 1) ? $urandom : clock_ms;
			offer(op, now, etime, pin, lvl, tag);
			if (op <= OP_CLEAR)
				counted++;
		end
		s_tvalid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog
	initial begin
		#6000000;
		$display("status: fail");
		$finish;
	end

endmodule
